FILE: rtl/core/stup_pkg.sv
package stup_pkg;

   // result and string geometry
   localparam int VALUE_WIDTH = 64;
   localparam int MAX_LEN     = 4096;
   localparam int POS_W       = $clog2(MAX_LEN + 1);
   localparam int BASE_W      = 6;
   localparam int CHAR_W      = 8;
   localparam int DIGIT_W     = 6;
   localparam int MAC_W       = VALUE_WIDTH + BASE_W + 1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // bases
   localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
   localparam logic [BASE_W-1:0] BASE_BIN  = 6'd2;
   localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
   localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

   // characters
   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_B   = 8'h42;
   localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
   localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_B   = 8'h62;
   localparam logic [CHAR_W-1:0] CH_LO_X   = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
   localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   // one classified byte as it travels from front to back
   typedef struct packed {
      logic               is_nul;
      logic               is_space;
      logic               is_minus;
      logic               is_plus;
      logic               is_zero;
      logic               is_x;
      logic               is_b;
      logic               digit_ok;
      logic [DIGIT_W-1:0] digit;
      logic [BASE_W-1:0]  base;
   } stup_byte_type;

endpackage

FILE: rtl/core/stup_front.sv
module stup_front (
   input  logic [stup_pkg::CHAR_W-1:0] char_in,
   input  logic [stup_pkg::BASE_W-1:0] number_base,
   output stup_pkg::stup_byte_type     byte_out
);
   import stup_pkg::*;

   // character classes and digit value
   always_comb begin
      byte_out          = '0;
      byte_out.base     = number_base;
      byte_out.is_nul   = (char_in == CH_NUL);
      byte_out.is_space = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);
      byte_out.is_minus = (char_in == CH_MINUS);
      byte_out.is_plus  = (char_in == CH_PLUS);
      byte_out.is_zero  = (char_in == CH_ZERO);
      byte_out.is_x     = (char_in == CH_LO_X) || (char_in == CH_UP_X);
      byte_out.is_b     = (char_in == CH_LO_B) || (char_in == CH_UP_B);
      if (char_in >= CH_ZERO && char_in <= CH_NINE) begin
         byte_out.digit_ok = 1'b1;
         byte_out.digit    = DIGIT_W'(char_in - CH_ZERO);
      end else if (char_in >= CH_LO_A && char_in <= CH_LO_Z) begin
         byte_out.digit_ok = 1'b1;
         byte_out.digit    = DIGIT_W'(char_in - CH_LO_A + LETTER_OFS);
      end else if (char_in >= CH_UP_A && char_in <= CH_UP_Z) begin
         byte_out.digit_ok = 1'b1;
         byte_out.digit    = DIGIT_W'(char_in - CH_UP_A + LETTER_OFS);
      end
   end

endmodule

FILE: rtl/core/stup_queue.sv
module stup_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  stup_pkg::stup_byte_type push_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output stup_pkg::stup_byte_type head_data
);
   import stup_pkg::*;

   stup_byte_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/stup_back.sv
module stup_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  stup_pkg::stup_byte_type          head_data,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [stup_pkg::VALUE_WIDTH-1:0] rsp_value,
   output logic [stup_pkg::POS_W-1:0]       rsp_end_offset,
   output logic                             rsp_overflowed,
   output logic                             rsp_bad_base
);
   import stup_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [BASE_W-1:0]       wb_ff, wb_in;
   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;
   logic                    ovf_ff, ovf_in;
   logic                    neg_ff, neg_in;
   logic [POS_W-1:0]        pos_ff, pos_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]  value_ff;
   logic [POS_W-1:0]        offset_ff;
   logic                    ovf_out_ff;
   logic                    bad_ff;

   logic                    process;
   logic                    emit;
   logic                    emit_bad;
   logic                    try_digit;
   logic [BASE_W-1:0]       tb;
   logic [MAC_W-1:0]        mac;
   logic                    mac_ovf;
   logic [VALUE_WIDTH-1:0]  result_value;

   // one byte per cycle while the output register can take a result
   assign process = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop     = process;

   // multiply-add on the base in use; high bits flag exact overflow
   assign mac     = MAC_W'(acc_ff) * MAC_W'(tb) + MAC_W'(head_data.digit);
   assign mac_ovf = |mac[MAC_W-1:VALUE_WIDTH];

   assign result_value = ovf_ff ? {VALUE_WIDTH{1'b1}} :
                         neg_ff ? (VALUE_WIDTH'(0) - acc_ff) : acc_ff;

   // parser next state
   always_comb begin
      phase_in  = phase_ff;
      wb_in     = wb_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      neg_in    = neg_ff;
      pos_in    = pos_ff;
      emit      = 1'b0;
      emit_bad  = 1'b0;
      try_digit = 1'b0;
      tb        = wb_ff;
      case (phase_ff)
         PH_SPACE: begin
            wb_in = head_data.base;
            if (head_data.base == BASE_ONE || head_data.base > BASE_MAX) begin
               emit_bad = 1'b1;
               phase_in = PH_DONE;
            end else if (head_data.is_space) begin
               phase_in = PH_SPACE;
            end else if (head_data.is_minus) begin
               neg_in   = 1'b1;
               phase_in = PH_SIGNED;
            end else if (head_data.is_plus) begin
               phase_in = PH_SIGNED;
            end else if (head_data.is_zero) begin
               phase_in = PH_ZERO;
            end else begin
               tb        = (head_data.base == BASE_AUTO) ? BASE_DEC : head_data.base;
               try_digit = 1'b1;
            end
         end
         PH_SIGNED: begin
            if (head_data.is_zero) begin
               phase_in = PH_ZERO;
            end else begin
               tb        = (wb_ff == BASE_AUTO) ? BASE_DEC : wb_ff;
               try_digit = 1'b1;
            end
         end
         PH_ZERO: begin
            if (head_data.is_x && (wb_ff == BASE_AUTO || wb_ff == BASE_HEX)) begin
               wb_in    = BASE_HEX;
               phase_in = PH_DIGITS;
            end else if (head_data.is_b && (wb_ff == BASE_AUTO || wb_ff == BASE_BIN)) begin
               wb_in    = BASE_BIN;
               phase_in = PH_DIGITS;
            end else begin
               tb        = (wb_ff == BASE_AUTO) ? BASE_OCT : wb_ff;
               try_digit = 1'b1;
            end
         end
         PH_DIGITS: begin
            try_digit = 1'b1;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      // digit accumulate or end of number
      if (try_digit) begin
         wb_in = tb;
         if (head_data.digit_ok && tb >= BASE_BIN && BASE_W'(head_data.digit) < tb) begin
            acc_in   = mac[VALUE_WIDTH-1:0];
            ovf_in   = ovf_ff | mac_ovf;
            phase_in = PH_DIGITS;
         end else begin
            emit     = 1'b1;
            phase_in = PH_DONE;
         end
      end

      // terminator rearms, otherwise position saturates
      if (head_data.is_nul) begin
         phase_in = PH_SPACE;
         wb_in    = '0;
         acc_in   = '0;
         ovf_in   = 1'b0;
         neg_in   = 1'b0;
         pos_in   = '0;
      end else if (pos_ff != POS_W'(MAX_LEN)) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         wb_ff    <= '0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         pos_ff   <= '0;
      end else if (process) begin
         phase_ff <= phase_in;
         wb_ff    <= wb_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         neg_ff   <= neg_in;
         pos_ff   <= pos_in;
      end
   end

   // output register
   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (process && (emit || emit_bad));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process && emit_bad) begin
         value_ff   <= '0;
         offset_ff  <= '0;
         ovf_out_ff <= 1'b0;
         bad_ff     <= 1'b1;
      end else if (process && emit) begin
         value_ff   <= result_value;
         offset_ff  <= pos_ff;
         ovf_out_ff <= ovf_ff;
         bad_ff     <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = value_ff;
   assign rsp_end_offset = offset_ff;
   assign rsp_overflowed = ovf_out_ff;
   assign rsp_bad_base   = bad_ff;

endmodule

FILE: rtl/core/string_to_unsigned_parser_top.sv
// Streaming string-to-unsigned converter. Send a NUL-terminated string one byte per
// transfer on req_; leading whitespace is skipped, one sign is taken, and with
// csr number_base 0 (autodetect), 16, 2 or 8 the 0x, 0b or lone 0 prefix selects the
// base; digits then accumulate up to base 36. At the first non-digit one result
// leaves on rsp_: the 64-bit value (two's complement if negative, all ones on
// overflow), the end offset and the overflow and bad-base flags. Bytes after that are
// dropped until NUL, which rearms the parser. The block takes one byte every cycle
// while its queue has room: the front classifies each byte into a two-entry queue
// and the back consumes one entry per cycle through a single 64x6 multiply-add; each
// byte waits in the queue and its result in the output register, and the back stalls
// only while a result is waiting on rsp_ready. number_base is sampled while whitespace
// is skipped; write it only while the block is idle.
module string_to_unsigned_parser_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [stup_pkg::CHAR_W-1:0]      req_char_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [stup_pkg::VALUE_WIDTH-1:0] rsp_value,
   output logic [stup_pkg::POS_W-1:0]       rsp_end_offset,
   output logic                             rsp_overflowed,
   output logic                             rsp_bad_base,
   input  logic                             csr_wr_en,
   input  logic [stup_pkg::BASE_W-1:0]      csr_wr_data
);
   import stup_pkg::*;

   logic [BASE_W-1:0] number_base_ff;
   stup_byte_type     class_byte;
   stup_byte_type     head_data;
   logic              queue_full;
   logic              head_valid;
   logic              pop;
   logic              push;

   // base register
   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= '0;
      end else if (csr_wr_en) begin
         number_base_ff <= csr_wr_data;
      end
   end

   // input transfer lands in the queue
   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   stup_front u_front (
      .char_in     (req_char_in),
      .number_base (number_base_ff),
      .byte_out    (class_byte)
   );

   stup_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (class_byte),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   stup_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_end_offset (rsp_end_offset),
      .rsp_overflowed (rsp_overflowed),
      .rsp_bad_base   (rsp_bad_base)
   );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import stup_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BYTES = 240;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [POS_W-1:0]       end_offset;
      logic                   overflowed;
      logic                   bad_base;
   } parse_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CHAR_W-1:0]      req_char_in;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [VALUE_WIDTH-1:0] rsp_value;
   logic [POS_W-1:0]       rsp_end_offset;
   logic                   rsp_overflowed;
   logic                   rsp_bad_base;
   logic                   csr_wr_en;
   logic [BASE_W-1:0]      csr_wr_data;

   // parser shadow state
   logic [BASE_W-1:0]      base_shadow;
   phase_type              scan_phase;
   logic [BASE_W-1:0]      active_base;
   logic [VALUE_WIDTH-1:0] acc_value;
   logic                   acc_overflow;
   logic                   minus_seen;
   logic [POS_W-1:0]       char_pos;

   parse_result_type expected_numbers[$];
   parse_result_type want_number;
   parse_result_type got_number;

   int send_idle_pct;
   int rsp_stall_pct;
   int mismatch_count;
   int cycle_count;
   int bytes_sent;

   string_to_unsigned_parser_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_in    (req_char_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_end_offset (rsp_end_offset),
      .rsp_overflowed (rsp_overflowed),
      .rsp_bad_base   (rsp_bad_base),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("string_to_unsigned_parser_top test failed");
         $finish;
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_number = '{rsp_value, rsp_end_offset, rsp_overflowed, rsp_bad_base};
         if (expected_numbers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: value %h offset %0d ovf %b bad %b",
                        got_number.value, got_number.end_offset,
                        got_number.overflowed, got_number.bad_base);
         end else begin
            want_number = expected_numbers.pop_front();
            if (got_number != want_number) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected value %h offset %0d ovf %b bad %b,",
                            " got value %h offset %0d ovf %b bad %b"},
                           want_number.value, want_number.end_offset,
                           want_number.overflowed, want_number.bad_base,
                           got_number.value, got_number.end_offset,
                           got_number.overflowed, got_number.bad_base);
            end
         end
      end
   end

   function automatic int digit_of(input logic [CHAR_W-1:0] c);
      if (c >= CH_ZERO && c <= CH_NINE)
         return int'(c - CH_ZERO);
      if (c >= CH_LO_A && c <= CH_LO_Z)
         return int'(c - CH_LO_A + LETTER_OFS);
      if (c >= CH_UP_A && c <= CH_UP_Z)
         return int'(c - CH_UP_A + LETTER_OFS);
      return -1;
   endfunction

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   task automatic clear_scan();
      scan_phase   = PH_SPACE;
      active_base  = BASE_AUTO;
      acc_value    = '0;
      acc_overflow = 1'b0;
      minus_seen   = 1'b0;
      char_pos     = '0;
   endtask

   // accumulate one digit or close the number
   task automatic digit_step(input logic [CHAR_W-1:0] c);
      int d;
      logic [VALUE_WIDTH+6:0] prod;
      parse_result_type res;
      d = digit_of(c);
      scan_phase = PH_DIGITS;
      if (d >= 0 && active_base >= BASE_BIN && d < active_base) begin
         prod = (VALUE_WIDTH+7)'(acc_value) * (VALUE_WIDTH+7)'(active_base)
                + (VALUE_WIDTH+7)'(d);
         if (prod[VALUE_WIDTH+6:VALUE_WIDTH] != '0)
            acc_overflow = 1'b1;
         acc_value = prod[VALUE_WIDTH-1:0];
      end else begin
         if (acc_overflow)
            res.value = '1;
         else if (minus_seen)
            res.value = '0 - acc_value;
         else
            res.value = acc_value;
         res.end_offset = char_pos;
         res.overflowed = acc_overflow;
         res.bad_base   = 1'b0;
         expected_numbers.push_back(res);
         scan_phase = PH_DONE;
      end
   endtask

   // predict the effect of one transferred byte
   task automatic predict_char(input logic [CHAR_W-1:0] c);
      case (scan_phase)
         PH_SPACE: begin
            active_base = base_shadow;
            if (active_base == BASE_ONE || active_base > BASE_MAX) begin
               expected_numbers.push_back(parse_result_type'{'0, '0, 1'b0, 1'b1});
               scan_phase = PH_DONE;
            end else if (is_blank(c)) begin
               scan_phase = PH_SPACE;
            end else if (c == CH_MINUS) begin
               minus_seen = 1'b1;
               scan_phase = PH_SIGNED;
            end else if (c == CH_PLUS) begin
               scan_phase = PH_SIGNED;
            end else if (c == CH_ZERO) begin
               scan_phase = PH_ZERO;
            end else begin
               if (active_base == BASE_AUTO)
                  active_base = BASE_DEC;
               digit_step(c);
            end
         end
         PH_SIGNED: begin
            if (c == CH_ZERO) begin
               scan_phase = PH_ZERO;
            end else begin
               if (active_base == BASE_AUTO)
                  active_base = BASE_DEC;
               digit_step(c);
            end
         end
         PH_ZERO: begin
            if ((c == CH_LO_X || c == CH_UP_X) &&
                (active_base == BASE_AUTO || active_base == BASE_HEX)) begin
               active_base = BASE_HEX;
               scan_phase  = PH_DIGITS;
            end else if ((c == CH_LO_B || c == CH_UP_B) &&
                         (active_base == BASE_AUTO || active_base == BASE_BIN)) begin
               active_base = BASE_BIN;
               scan_phase  = PH_DIGITS;
            end else begin
               if (active_base == BASE_AUTO)
                  active_base = BASE_OCT;
               digit_step(c);
            end
         end
         PH_DIGITS: digit_step(c);
         default: ;
      endcase
      if (c == CH_NUL)
         clear_scan();
      else if (char_pos < MAX_LEN)
         char_pos++;
   endtask

   // one byte transfer, with random sender gaps
   task automatic send_char(input logic [CHAR_W-1:0] c);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      do @(posedge clock); while (!req_ready);
      predict_char(c);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         send_char(s[i]);
      send_char(CH_NUL);
   endtask

   // wait until all results are in and the pipeline is empty
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_numbers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_number_base(input logic [BASE_W-1:0] b);
      settle_block();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= b;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      base_shadow = b;
   endtask

   // random string: mostly well formed, some noise
   task automatic send_random_string();
      int kind;
      int eff;
      int ndig;
      int i;
      int d;
      logic [CHAR_W-1:0] c;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 8)) send_char(CHAR_W'($urandom_range(1, 255)));
         send_char(CH_NUL);
         return;
      end
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(5) == 5)
            send_char(CH_SPACE);
         else
            send_char(CH_TAB + CHAR_W'($urandom_range(0, 4)));
      end
      case ($urandom_range(0, 3))
         0: send_char(CH_MINUS);
         1: send_char(CH_PLUS);
         default: ;
      endcase
      eff = int'(base_shadow);
      kind = $urandom_range(0, 4);
      case (kind)
         0: begin
            send_char(CH_ZERO);
            send_char($urandom_range(1) ? CH_LO_X : CH_UP_X);
            if (base_shadow == BASE_AUTO) eff = int'(BASE_HEX);
         end
         1: begin
            send_char(CH_ZERO);
            send_char($urandom_range(1) ? CH_LO_B : CH_UP_B);
            if (base_shadow == BASE_AUTO) eff = int'(BASE_BIN);
         end
         2: begin
            send_char(CH_ZERO);
            if (base_shadow == BASE_AUTO) eff = int'(BASE_OCT);
         end
         default: if (base_shadow == BASE_AUTO) eff = int'(BASE_DEC);
      endcase
      if (eff < int'(BASE_BIN) || eff > int'(BASE_MAX))
         eff = int'(BASE_DEC);
      ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 10);
      for (i = 0; i < ndig; i++) begin
         d = $urandom_range(0, eff - 1);
         if (d < 10)
            c = CH_ZERO + CHAR_W'(d);
         else
            c = ($urandom_range(1) ? CH_LO_A : CH_UP_A) + CHAR_W'(d) - LETTER_OFS;
         send_char(c);
      end
      if ($urandom_range(0, 2) != 0) begin
         send_char(CHAR_W'($urandom_range(1, 255)));
         repeat ($urandom_range(0, 3)) send_char(CHAR_W'($urandom_range(1, 255)));
      end
      send_char(CH_NUL);
   endtask

   // autodetect: whitespace, signs, prefixes, empty and digitless strings
   task automatic test_prefixes_and_signs();
      logic [CHAR_W-1:0] c;
      write_number_base(BASE_AUTO);
      for (c = CH_TAB; c <= CH_CR; c++)
         send_char(c);
      send_char(CH_SPACE);
      send_text("42");
      send_text("-0x1f");
      send_text("+0b101!");
      send_text("017");
      send_text("0x");
      send_text("0B");
      send_text("");
      send_text("-");
      send_text("12;x");
      send_char(8'h35);
      send_char(8'hFF);
      send_char(CH_NUL);
   endtask

   // fixed bases and prefixes they do or do not allow
   task automatic test_fixed_bases();
      write_number_base(BASE_HEX);
      send_text("0xFfAa");
      send_text("Cafe");
      write_number_base(BASE_OCT);
      send_text("0x7");
      send_text("0778");
      write_number_base(BASE_BIN);
      send_text("0b1101");
      send_text("102");
      write_number_base(BASE_DEC);
      send_text("0b1");
      send_text("-99");
      write_number_base(BASE_MAX);
      send_text("zZ9");
   endtask

   // exact overflow detection, sign overridden
   task automatic test_overflow();
      write_number_base(BASE_AUTO);
      send_text("18446744073709551615");
      send_text("18446744073709551616");
      send_text("-18446744073709551616");
      send_text("-18446744073709551615");
      send_text("0xFFFFFFFFFFFFFFFF");
      send_text("0x10000000000000000");
      write_number_base(BASE_MAX);
      send_text("zzzzzzzzzzzzzz");
   endtask

   // invalid bases report on the first byte
   task automatic test_bad_base();
      write_number_base(BASE_ONE);
      send_text("  5");
      write_number_base(BASE_MAX + 6'd1);
      send_text("12");
      send_text("");
      write_number_base('1);
      send_text("0x1");
   endtask

   // random strings over all idling phases and many bases
   task automatic test_random_strings();
      int phase_idx;
      int target;
      logic [BASE_W-1:0] base_pick[12];
      base_pick = '{BASE_AUTO, BASE_AUTO, BASE_AUTO, BASE_BIN, BASE_OCT, BASE_DEC,
                    BASE_HEX, BASE_MAX, BASE_ONE, BASE_MAX + 6'd1, '1, BASE_AUTO};
      target = bytes_sent;
      for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
         case (phase_idx)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 61; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 61; end
            default: begin send_idle_pct = 15; rsp_stall_pct = 15; end
         endcase
         target += RANDOM_BYTES / 4;
         while (bytes_sent < target) begin
            if ($urandom_range(3) == 0)
               write_number_base(BASE_W'($urandom_range(2, 36)));
            else
               write_number_base(base_pick[$urandom_range(0, 11)]);
            repeat (3) send_random_string();
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_char_in    = '0;
      rsp_ready      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      bytes_sent     = 0;
      base_shadow    = BASE_AUTO;
      clear_scan();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_prefixes_and_signs();
      test_fixed_bases();
      test_overflow();
      test_bad_base();
      test_random_strings();

      settle_block();
      if (mismatch_count == 0 && expected_numbers.size() == 0)
         $display("string_to_unsigned_parser_top test passed");
      else
         $display("string_to_unsigned_parser_top test failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/stup_pkg.sv
rtl/core/stup_front.sv
rtl/core/stup_queue.sv
rtl/core/stup_back.sv
rtl/core/string_to_unsigned_parser_top.sv
bench/testbench.sv
